@@ design/sihp_pkg.sv @@
// Shared types, constants and parse-step helpers for the signed item header parser.
// Used by every other design file and the testbench. No dependencies.
package sihp_pkg;

   typedef enum logic [3:0] {
      PH_TYPE0, PH_TYPE1, PH_SIG, PH_OWNER, PH_OPTFLAG, PH_OPTBYTES,
      PH_COUNTS, PH_CNT, PH_BSIZE, PH_NSIZE, PH_NAME, PH_VSIZE, PH_VALUE,
      PH_HOLD, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      V_PENDING, V_OK, V_FAILED, V_FALLBACK
   } verdict_type;

   localparam logic [3:0] ROLE_SIGTYPE     = 4'd0;
   localparam logic [3:0] ROLE_SIG         = 4'd1;
   localparam logic [3:0] ROLE_OWNER       = 4'd2;
   localparam logic [3:0] ROLE_TARGET_FLAG = 4'd3;
   localparam logic [3:0] ROLE_TARGET      = 4'd4;
   localparam logic [3:0] ROLE_ANCHOR_FLAG = 4'd5;
   localparam logic [3:0] ROLE_ANCHOR      = 4'd6;
   localparam logic [3:0] ROLE_COUNTS      = 4'd7;
   localparam logic [3:0] ROLE_BLOCK       = 4'd8;
   localparam logic [3:0] ROLE_NAME_SIZE   = 4'd9;
   localparam logic [3:0] ROLE_NAME        = 4'd10;
   localparam logic [3:0] ROLE_VALUE_SIZE  = 4'd11;
   localparam logic [3:0] ROLE_VALUE       = 4'd12;
   localparam logic [3:0] ROLE_IGNORED     = 4'd13;

   localparam logic [15:0] SIG_RSA     = 16'd1;
   localparam logic [15:0] SIG_ED_A    = 16'd2;
   localparam logic [15:0] SIG_ECDSA   = 16'd3;
   localparam logic [15:0] SIG_ED_B    = 16'd4;
   localparam logic [15:0] SIG_ETH     = 16'd7;

   localparam logic [63:0] LEN_512   = 64'd512;
   localparam logic [63:0] LEN_65    = 64'd65;
   localparam logic [63:0] LEN_64    = 64'd64;
   localparam logic [63:0] LEN_42    = 64'd42;
   localparam logic [63:0] LEN_32    = 64'd32;
   localparam logic [63:0] LEN_OPT   = 64'd32;
   localparam logic [63:0] LEN_COUNT = 64'd16;
   localparam logic [3:0]  VARINT_MAX_BYTES = 4'd9;

   typedef struct packed {
      phase_type   phase;
      logic [63:0] field_left;
      logic [15:0] sig_kind;
      logic        optional_index;
      logic [63:0] declared_tags;
      logic [63:0] section_bytes;
      logic [63:0] section_left;
      logic        in_block;
      logic [63:0] block_left;
      logic [62:0] run_left;
      logic [63:0] tags_seen;
      logic [62:0] varint_value;
      logic [3:0]  varint_bytes;
      verdict_type held_verdict;
      logic        fallback_held;
      logic        target_flag;
   } state_type;

   typedef struct packed {
      logic [3:0]  byte_role;
      logic [31:0] tag_index;
      verdict_type verdict;
      logic [63:0] header_length;
      logic [15:0] signature_type;
      logic        target_present;
   } rsp_type;

   function automatic state_type reset_state();
      state_type s;
      s = '0;
      s.phase = PH_TYPE0;
      s.held_verdict = V_PENDING;
      return s;
   endfunction

   function automatic state_type finish(state_type s, verdict_type v);
      s.held_verdict = v;
      s.phase = PH_DONE;
      return s;
   endfunction

   function automatic logic [63:0] cur_bound(state_type s);
      return s.in_block ? s.block_left : s.section_left;
   endfunction

   function automatic state_type start_varint(state_type s, phase_type ph);
      s.phase = ph;
      s.varint_value = '0;
      s.varint_bytes = '0;
      return s;
   endfunction

   function automatic state_type enter_count(state_type s);
      if (s.section_left == 64'd0) return finish(s, V_FAILED);
      return start_varint(s, PH_CNT);
   endfunction

   function automatic state_type end_run(state_type s);
      if (s.in_block) begin
         if (s.block_left != 64'd0) return finish(s, V_FAILED);
         s.in_block = 1'b0;
      end
      return enter_count(s);
   endfunction

   function automatic state_type next_in_run(state_type s);
      if (s.run_left == 63'd0) return end_run(s);
      if (cur_bound(s) == 64'd0) return finish(s, V_FAILED);
      return start_varint(s, PH_NSIZE);
   endfunction

   function automatic state_type push_tag(state_type s);
      if (s.tags_seen != '1) s.tags_seen = s.tags_seen + 64'd1;
      if (s.run_left != 63'd0) s.run_left = s.run_left - 63'd1;
      return next_in_run(s);
   endfunction

   function automatic state_type take_value(state_type s, logic neg, logic [63:0] mag);
      if (neg) return finish(s, V_FAILED);
      if (mag == 64'd0) return push_tag(s);
      if (mag > cur_bound(s)) return finish(s, V_FAILED);
      s.phase = PH_VALUE;
      s.field_left = mag;
      return s;
   endfunction

   function automatic state_type take_bsize(state_type s, logic neg, logic [63:0] mag);
      if (neg || (mag > s.section_left)) return finish(s, V_FAILED);
      s.block_left = mag;
      s.in_block = 1'b1;
      return next_in_run(s);
   endfunction

   function automatic state_type enter_vsize(state_type s);
      if (cur_bound(s) == 64'd0) return take_value(s, 1'b0, 64'd0);
      return start_varint(s, PH_VSIZE);
   endfunction

endpackage

@@ design/sihp_step.sv @@
// Combinational parse step: next state and result fields for one byte.
// Depends on sihp_pkg.
module sihp_step #(
   parameter int COUNTER_BITS = 64
) (
   input  sihp_pkg::state_type    cur_state,
   input  logic [COUNTER_BITS-1:0] cur_pos,
   input  logic [7:0]             data_byte,
   input  logic                   window_end,
   output sihp_pkg::state_type    next_state,
   output logic [COUNTER_BITS-1:0] next_pos,
   output sihp_pkg::rsp_type      result
);
   import sihp_pkg::*;

   function automatic state_type varint_done(state_type s);
      logic        neg;
      logic [63:0] mag;
      neg = s.varint_value[0];
      mag = {2'b00, s.varint_value[62:1]};
      case (s.phase)
         PH_CNT: begin
            if (!neg && mag == 64'd0) begin
               if (s.section_left == 64'd0)
                  return finish(s, (s.tags_seen == s.declared_tags) ? V_OK : V_FAILED);
               return finish(s, V_FAILED);
            end else if (!neg) begin
               s.run_left = mag[62:0];
               s.in_block = 1'b0;
               return next_in_run(s);
            end
            s.run_left = mag[62:0] + 63'd1;
            if (s.section_left == 64'd0) return take_bsize(s, 1'b0, 64'd0);
            return start_varint(s, PH_BSIZE);
         end
         PH_BSIZE: return take_bsize(s, neg, mag);
         PH_NSIZE: begin
            if (!neg && mag == 64'd0) return end_run(s);
            if (neg || mag > cur_bound(s)) return finish(s, V_FAILED);
            s.phase = PH_NAME;
            s.field_left = mag;
            return s;
         end
         default: return take_value(s, neg, mag);
      endcase
   endfunction

   function automatic state_type section_byte(state_type s, logic [7:0] b);
      logic [5:0] sh;
      if (s.section_left != 64'd0) s.section_left = s.section_left - 64'd1;
      if (s.in_block && s.block_left != 64'd0) s.block_left = s.block_left - 64'd1;
      case (s.phase) inside
         PH_CNT, PH_BSIZE, PH_NSIZE, PH_VSIZE: begin
            if (s.varint_bytes >= VARINT_MAX_BYTES) begin
               s.fallback_held = 1'b1;
               s.phase = PH_HOLD;
               if (s.section_left == 64'd0) return finish(s, V_FALLBACK);
               return s;
            end
            sh = {2'b00, s.varint_bytes} * 6'd7;
            s.varint_value = s.varint_value | (63'(b[6:0]) << sh);
            s.varint_bytes = s.varint_bytes + 4'd1;
            if (!b[7] || cur_bound(s) == 64'd0) return varint_done(s);
            return s;
         end
         PH_NAME: begin
            if (s.field_left != 64'd0) s.field_left = s.field_left - 64'd1;
            if (s.field_left == 64'd0) return enter_vsize(s);
            return s;
         end
         PH_VALUE: begin
            if (s.field_left != 64'd0) s.field_left = s.field_left - 64'd1;
            if (s.field_left == 64'd0) return push_tag(s);
            return s;
         end
         default: begin
            if (s.section_left == 64'd0) return finish(s, V_FALLBACK);
            return s;
         end
      endcase
   endfunction

   function automatic state_type header_byte(state_type s, logic [7:0] b);
      logic [4:0] idx;
      case (s.phase)
         PH_TYPE0: begin
            s.sig_kind = {8'h00, b};
            s.phase = PH_TYPE1;
         end
         PH_TYPE1: begin
            s.sig_kind = {b, s.sig_kind[7:0]};
            case (s.sig_kind) inside
               SIG_RSA:          begin s.field_left = LEN_512; s.block_left = LEN_512; end
               SIG_ED_A, SIG_ED_B: begin s.field_left = LEN_64; s.block_left = LEN_32; end
               SIG_ECDSA:        begin s.field_left = LEN_65; s.block_left = LEN_65; end
               SIG_ETH:          begin s.field_left = LEN_65; s.block_left = LEN_42; end
               default:          return finish(s, V_FAILED);
            endcase
            s.phase = PH_SIG;
         end
         PH_SIG: begin
            s.field_left = s.field_left - 64'd1;
            if (s.field_left == 64'd0) begin
               s.field_left = s.block_left;
               s.block_left = '0;
               s.phase = PH_OWNER;
            end
         end
         PH_OWNER: begin
            s.field_left = s.field_left - 64'd1;
            if (s.field_left == 64'd0) begin
               s.phase = PH_OPTFLAG;
               s.optional_index = 1'b0;
            end
         end
         PH_OPTFLAG: begin
            if (b == 8'd1) begin
               if (!s.optional_index) s.target_flag = 1'b1;
               s.field_left = LEN_OPT;
               s.phase = PH_OPTBYTES;
            end else if (b == 8'd0) begin
               if (!s.optional_index) s.optional_index = 1'b1;
               else begin
                  s.phase = PH_COUNTS;
                  s.field_left = LEN_COUNT;
               end
            end else begin
               return finish(s, V_FAILED);
            end
         end
         PH_OPTBYTES: begin
            s.field_left = s.field_left - 64'd1;
            if (s.field_left == 64'd0) begin
               if (!s.optional_index) begin
                  s.optional_index = 1'b1;
                  s.phase = PH_OPTFLAG;
               end else begin
                  s.phase = PH_COUNTS;
                  s.field_left = LEN_COUNT;
               end
            end
         end
         default: begin
            idx = 5'd16 - s.field_left[4:0];
            if (!idx[3]) s.declared_tags[{idx[2:0], 3'b000} +: 8] = b;
            else         s.section_bytes[{idx[2:0], 3'b000} +: 8] = b;
            s.field_left = s.field_left - 64'd1;
            if (s.field_left == 64'd0) begin
               if (s.declared_tags == 64'd0 && s.section_bytes == 64'd0)
                  return finish(s, V_OK);
               s.section_left = s.section_bytes;
               s.tags_seen = '0;
               s.in_block = 1'b0;
               return enter_count(s);
            end
         end
      endcase
      return s;
   endfunction

   state_type   stepped;
   verdict_type verdict;
   logic [3:0]  role;

   always_comb begin
      unique case (cur_state.phase)
         PH_TYPE0, PH_TYPE1: role = ROLE_SIGTYPE;
         PH_SIG:             role = ROLE_SIG;
         PH_OWNER:           role = ROLE_OWNER;
         PH_OPTFLAG:         role = cur_state.optional_index ? ROLE_ANCHOR_FLAG : ROLE_TARGET_FLAG;
         PH_OPTBYTES:        role = cur_state.optional_index ? ROLE_ANCHOR : ROLE_TARGET;
         PH_COUNTS:          role = ROLE_COUNTS;
         PH_CNT, PH_BSIZE:   role = ROLE_BLOCK;
         PH_NSIZE:           role = ROLE_NAME_SIZE;
         PH_NAME:            role = ROLE_NAME;
         PH_VSIZE:           role = ROLE_VALUE_SIZE;
         PH_VALUE:           role = ROLE_VALUE;
         default:            role = ROLE_IGNORED;
      endcase
   end

   always_comb begin
      stepped  = cur_state;
      next_pos = cur_pos;
      if (cur_state.phase != PH_DONE) begin
         if (cur_pos != '1) next_pos = cur_pos + 1'b1;
         if (cur_state.phase >= PH_CNT) stepped = section_byte(cur_state, data_byte);
         else                           stepped = header_byte(cur_state, data_byte);
      end

      verdict = (stepped.phase == PH_DONE) ? stepped.held_verdict : V_PENDING;
      if (window_end && stepped.phase != PH_DONE) verdict = V_FAILED;

      result.byte_role = role;
      if (role >= ROLE_NAME_SIZE && role <= ROLE_VALUE)
         result.tag_index = (cur_state.tags_seen[63:32] != 32'd0) ? '1
                                                                 : cur_state.tags_seen[31:0];
      else
         result.tag_index = '0;
      result.verdict        = verdict;
      result.header_length  = (verdict == V_OK) ? 64'(next_pos) : 64'd0;
      result.signature_type = stepped.sig_kind;
      result.target_present = stepped.target_flag;

      next_state = stepped;
      if (window_end) begin
         next_state = reset_state();
         next_pos   = '0;
      end
   end

endmodule

@@ design/sihp_out_reg.sv @@
// Result register with valid/stall handshake toward the consumer.
// Depends on sihp_pkg.
module sihp_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  sihp_pkg::rsp_type load_data,
   input  logic              stall,
   output logic              valid,
   output logic              free,
   output sihp_pkg::rsp_type data
);
   import sihp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      free     = !valid_ff || !stall;
      valid_in = load ? 1'b1 : (free ? 1'b0 : valid_ff);
      data_in  = load ? load_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

@@ design/signed_item_header_parser.sv @@
// Streaming header parser for a signed data item, one byte of the item window
// per beat. Each request beat yields exactly one response beat carrying the
// byte's role, its tag index, the running signature type and target flag, and
// the verdict (pending, ok, failed, fallback) with the header length on ok.
// Throughput is one byte per cycle: the parse state register is updated by a
// single combinational step per accepted byte, and results leave through one
// output register, so a new byte is taken whenever that register is empty or
// being drained. A response is valid in the cycle after its byte is taken.
// A window_end beat returns the parser to its start state for the next window.
// Depends on sihp_pkg, sihp_step and sihp_out_reg.
module signed_item_header_parser #(
   parameter int COUNTER_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_window_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_byte_role,
   output logic [31:0] rsp_tag_index,
   output logic [1:0]  rsp_verdict,
   output logic [63:0] rsp_header_length,
   output logic [15:0] rsp_signature_type,
   output logic        rsp_target_present
);
   import sihp_pkg::*;

   state_type               state_ff, state_in;
   logic [COUNTER_BITS-1:0] pos_ff, pos_in;
   rsp_type                 step_rsp, out_rsp;
   logic                    out_free;
   logic                    accept;

   // Take a beat whenever the result register can take its response.
   assign req_stall = !out_free;
   assign accept    = req_valid && out_free;

   sihp_step #(.COUNTER_BITS(COUNTER_BITS)) u_step (
      .cur_state  (state_ff),
      .cur_pos    (pos_ff),
      .data_byte  (req_data_byte),
      .window_end (req_window_end),
      .next_state (state_in),
      .next_pos   (pos_in),
      .result     (step_rsp)
   );

   // Advance the parse state only on an accepted beat; hold otherwise.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= reset_state();
         pos_ff   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   sihp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (step_rsp),
      .stall     (rsp_stall),
      .valid     (rsp_valid),
      .free      (out_free),
      .data      (out_rsp)
   );

   assign rsp_byte_role      = out_rsp.byte_role;
   assign rsp_tag_index      = out_rsp.tag_index;
   assign rsp_verdict        = out_rsp.verdict;
   assign rsp_header_length  = out_rsp.header_length;
   assign rsp_signature_type = out_rsp.signature_type;
   assign rsp_target_present = out_rsp.target_present;

endmodule

@@ design/sihp_checker.sv @@
// Port-level checks for signed_item_header_parser, attached by bind.
// Depends on sihp_pkg.
module sihp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        req_window_end,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_byte_role,
   input logic [31:0] rsp_tag_index,
   input logic [1:0]  rsp_verdict,
   input logic [63:0] rsp_header_length,
   input logic [15:0] rsp_signature_type,
   input logic        rsp_target_present
);
   import sihp_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict) && $stable(rsp_byte_role))
      else $error("stalled response changed");

   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != V_OK |-> rsp_header_length == 64'd0)
      else $error("header length without ok verdict");

   a_tix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_role < ROLE_NAME_SIZE || rsp_byte_role > ROLE_VALUE)
      |-> rsp_tag_index == 32'd0)
      else $error("tag index outside tag roles");

   a_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted beat gave no response");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

bind signed_item_header_parser sihp_checker u_sihp_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for signed_item_header_parser: directed beats, then random item windows.
// Each accepted byte is run through a local parse model. Depends on sihp_pkg and the RTL.
module testbench;
   import sihp_pkg::*;

   localparam int RANDOM_ITEMS = 550;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_window_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_byte_role;
   logic [31:0] rsp_tag_index;
   logic [1:0]  rsp_verdict;
   logic [63:0] rsp_header_length;
   logic [15:0] rsp_signature_type;
   logic        rsp_target_present;

   signed_item_header_parser dut (.*);

   always #10 clock = ~clock;

   // Local parse model state, kept apart from the RTL.
   typedef struct {
      phase_type   ph;
      logic [63:0] left, kind;
      bit          opt_idx;
      logic [63:0] tags_decl, sect_size, sect_left;
      bit          blk;
      logic [63:0] blk_left, run, tags_done, acc;
      int          nbytes;
      logic [63:0] pos;
      verdict_type held;
      bit          fb, tgt;
   } parse_state_t;

   parse_state_t st;
   rsp_type      due_beats[$];
   int           errors = 0;
   int           cycles = 0;
   int           idle_pct = 0, stall_pct = 0;
   bit           hold_request = 0, hold_done = 0;
   int           hold_left = 0;
   int           n_ok = 0, n_failed = 0, n_fallback = 0, n_windows = 0;

   function void clear_parse();
      st = '{ph: PH_TYPE0, held: V_PENDING, nbytes: 0, default: '0};
   endfunction

   function void conclude(verdict_type v);
      st.held = v;
      st.ph = PH_DONE;
   endfunction

   function logic [63:0] bound();
      return st.blk ? st.blk_left : st.sect_left;
   endfunction

   function void begin_varint(phase_type p);
      st.ph = p;
      st.acc = '0;
      st.nbytes = 0;
   endfunction

   function void open_count();
      if (st.sect_left == 0) conclude(V_FAILED);
      else begin_varint(PH_CNT);
   endfunction

   function void close_run();
      if (st.blk) begin
         if (st.blk_left != 0) begin
            conclude(V_FAILED);
            return;
         end
         st.blk = 0;
      end
      open_count();
   endfunction

   function void advance_run();
      if (st.run == 0) close_run();
      else if (bound() == 0) conclude(V_FAILED);
      else begin_varint(PH_NSIZE);
   endfunction

   function void count_tag();
      if (st.tags_done != '1) st.tags_done++;
      if (st.run != 0) st.run--;
      advance_run();
   endfunction

   function void accept_value_size(bit neg, logic [63:0] mag);
      if (neg) conclude(V_FAILED);
      else if (mag == 0) count_tag();
      else if (mag > bound()) conclude(V_FAILED);
      else begin
         st.ph = PH_VALUE;
         st.left = mag;
      end
   endfunction

   function void accept_block_size(bit neg, logic [63:0] mag);
      if (neg || mag > st.sect_left) begin
         conclude(V_FAILED);
         return;
      end
      st.blk_left = mag;
      st.blk = 1;
      advance_run();
   endfunction

   function void varint_complete();
      bit          neg;
      logic [63:0] mag;
      neg = st.acc[0];
      mag = st.acc >> 1;
      case (st.ph)
         PH_CNT: begin
            if (!neg && mag == 0) begin
               if (st.sect_left == 0 && st.tags_done == st.tags_decl) conclude(V_OK);
               else conclude(V_FAILED);
            end else if (!neg) begin
               st.run = mag;
               st.blk = 0;
               advance_run();
            end else begin
               st.run = mag + 1;
               if (st.sect_left == 0) accept_block_size(0, 0);
               else begin_varint(PH_BSIZE);
            end
         end
         PH_BSIZE: accept_block_size(neg, mag);
         PH_NSIZE: begin
            if (!neg && mag == 0) close_run();
            else if (neg || mag > bound()) conclude(V_FAILED);
            else begin
               st.ph = PH_NAME;
               st.left = mag;
            end
         end
         default: accept_value_size(neg, mag);
      endcase
   endfunction

   function void section_step(logic [7:0] b);
      if (st.sect_left != 0) st.sect_left--;
      if (st.blk && st.blk_left != 0) st.blk_left--;
      case (st.ph)
         PH_CNT, PH_BSIZE, PH_NSIZE, PH_VSIZE: begin
            // a tenth varint byte would land at shift 63: hold a fallback
            if (st.nbytes >= VARINT_MAX_BYTES) begin
               st.fb = 1;
               st.ph = PH_HOLD;
               if (st.sect_left == 0) conclude(V_FALLBACK);
               return;
            end
            st.acc |= 64'(b[6:0]) << (7 * st.nbytes);
            st.nbytes++;
            if (!b[7] || bound() == 0) varint_complete();
         end
         PH_NAME: begin
            if (st.left != 0) st.left--;
            if (st.left == 0) begin
               if (bound() == 0) accept_value_size(0, 0);
               else begin_varint(PH_VSIZE);
            end
         end
         PH_VALUE: begin
            if (st.left != 0) st.left--;
            if (st.left == 0) count_tag();
         end
         default: if (st.sect_left == 0) conclude(V_FALLBACK);
      endcase
   endfunction

   function void header_step(logic [7:0] b);
      logic [63:0] idx;
      case (st.ph)
         PH_TYPE0: begin
            st.kind = 64'(b);
            st.ph = PH_TYPE1;
         end
         PH_TYPE1: begin
            st.kind |= 64'(b) << 8;
            case (st.kind[15:0])
               SIG_RSA:            begin st.left = LEN_512; st.blk_left = LEN_512; end
               SIG_ED_A, SIG_ED_B: begin st.left = LEN_64;  st.blk_left = LEN_32;  end
               SIG_ECDSA:          begin st.left = LEN_65;  st.blk_left = LEN_65;  end
               SIG_ETH:            begin st.left = LEN_65;  st.blk_left = LEN_42;  end
               default: begin
                  conclude(V_FAILED);
                  return;
               end
            endcase
            st.ph = PH_SIG;
         end
         PH_SIG: begin
            st.left--;
            if (st.left == 0) begin
               st.left = st.blk_left;
               st.blk_left = 0;
               st.ph = PH_OWNER;
            end
         end
         PH_OWNER: begin
            st.left--;
            if (st.left == 0) begin
               st.ph = PH_OPTFLAG;
               st.opt_idx = 0;
            end
         end
         PH_OPTFLAG: begin
            if (b == 8'd1) begin
               if (!st.opt_idx) st.tgt = 1;
               st.left = LEN_OPT;
               st.ph = PH_OPTBYTES;
            end else if (b == 8'd0) begin
               if (!st.opt_idx) st.opt_idx = 1;
               else begin
                  st.ph = PH_COUNTS;
                  st.left = LEN_COUNT;
               end
            end else conclude(V_FAILED);
         end
         PH_OPTBYTES: begin
            st.left--;
            if (st.left == 0) begin
               if (!st.opt_idx) begin
                  st.opt_idx = 1;
                  st.ph = PH_OPTFLAG;
               end else begin
                  st.ph = PH_COUNTS;
                  st.left = LEN_COUNT;
               end
            end
         end
         default: begin
            idx = LEN_COUNT - st.left;
            if (idx < 8) st.tags_decl |= 64'(b) << (8 * idx);
            else st.sect_size |= 64'(b) << (8 * (idx - 8));
            st.left--;
            if (st.left == 0) begin
               if (st.tags_decl == 0 && st.sect_size == 0) begin
                  conclude(V_OK);
                  return;
               end
               st.sect_left = st.sect_size;
               st.tags_done = 0;
               st.blk = 0;
               open_count();
            end
         end
      endcase
   endfunction

   // Predict the response beat for one accepted request byte.
   function rsp_type parse_byte(logic [7:0] b, bit last);
      rsp_type r;
      r = '0;
      case (st.ph)
         PH_TYPE0, PH_TYPE1: r.byte_role = ROLE_SIGTYPE;
         PH_SIG:             r.byte_role = ROLE_SIG;
         PH_OWNER:           r.byte_role = ROLE_OWNER;
         PH_OPTFLAG:         r.byte_role = st.opt_idx ? ROLE_ANCHOR_FLAG : ROLE_TARGET_FLAG;
         PH_OPTBYTES:        r.byte_role = st.opt_idx ? ROLE_ANCHOR : ROLE_TARGET;
         PH_COUNTS:          r.byte_role = ROLE_COUNTS;
         PH_CNT, PH_BSIZE:   r.byte_role = ROLE_BLOCK;
         PH_NSIZE:           r.byte_role = ROLE_NAME_SIZE;
         PH_NAME:            r.byte_role = ROLE_NAME;
         PH_VSIZE:           r.byte_role = ROLE_VALUE_SIZE;
         PH_VALUE:           r.byte_role = ROLE_VALUE;
         default:            r.byte_role = ROLE_IGNORED;
      endcase
      if (r.byte_role >= ROLE_NAME_SIZE && r.byte_role <= ROLE_VALUE)
         r.tag_index = (st.tags_done > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : st.tags_done[31:0];
      if (st.ph != PH_DONE) begin
         if (st.pos != '1) st.pos++;
         if (st.ph >= PH_CNT) section_step(b);
         else header_step(b);
      end
      r.verdict = (st.ph == PH_DONE) ? st.held : V_PENDING;
      if (last && st.ph != PH_DONE) r.verdict = V_FAILED;
      r.header_length = (r.verdict == V_OK) ? st.pos : 64'd0;
      r.signature_type = st.kind[15:0];
      r.target_present = st.tgt;
      if (last) clear_parse();
      return r;
   endfunction

   // Offer one byte, wait for its beat, then queue the predicted response.
   task automatic send_byte(logic [7:0] b, bit last, bit typed = 0,
                            logic [3:0] role = ROLE_SIGTYPE,
                            verdict_type v = V_PENDING);
      rsp_type p;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_window_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = parse_byte(b, last);
      if (typed) begin
         p.byte_role = role;
         p.verdict = v;
      end
      due_beats.push_back(p);
      if (last) n_windows++;
   endtask

   task automatic push_varint(ref logic [7:0] q[$], input logic [63:0] v);
      do begin
         if ((v >> 7) != 0) q.push_back({1'b1, v[6:0]});
         else q.push_back({1'b0, v[6:0]});
         v = v >> 7;
      end while (v != 0);
   endtask

   // Build one tag section: plain runs and sized blocks, ending in a zero count.
   task automatic build_section(ref logic [7:0] sec[$], output int ntags);
      logic [7:0] body[$];
      int         nruns, n, nlen, vlen, made;
      bit         sized;
      ntags = 0;
      nruns = $urandom_range(0, 2);
      for (int r = 0; r < nruns; r++) begin
         body.delete();
         n = $urandom_range(1, 3);
         sized = $urandom_range(0, 1);
         made = 0;
         for (int t = 0; t < n; t++) begin
            nlen = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
            push_varint(body, 2 * nlen);
            if (nlen == 0) break;   // zero name size closes the run early
            repeat (nlen) body.push_back($urandom_range(0, 255));
            vlen = $urandom_range(0, 4);
            push_varint(body, 2 * vlen);
            repeat (vlen) body.push_back($urandom_range(0, 255));
            made++;
         end
         ntags += made;
         if (sized) begin
            push_varint(sec, 2 * n - 1);
            push_varint(sec, 2 * body.size());
         end else push_varint(sec, 2 * n);
         foreach (body[i]) sec.push_back(body[i]);
      end
      sec.push_back(8'h00);
   endtask

   // Build one random window; most are well formed, the rest broken or noise.
   task automatic build_window(ref logic [7:0] win[$]);
      logic [7:0]  sec[$];
      logic [15:0] kind;
      logic [63:0] decl, size;
      int          r, siglen, ownlen, ntags;
      win.delete();
      r = $urandom_range(0, 99);
      if (r < 40) kind = $urandom_range(0, 1) ? SIG_ED_A : SIG_ED_B;
      else if (r < 60) kind = SIG_ETH;
      else if (r < 72) kind = SIG_ECDSA;
      else if (r < 77) kind = SIG_RSA;
      else kind = $urandom_range(0, 65535);
      win.push_back(kind[7:0]);
      win.push_back(kind[15:8]);
      case (kind)
         SIG_RSA:            begin siglen = 512; ownlen = 512; end
         SIG_ED_A, SIG_ED_B: begin siglen = 64;  ownlen = 32;  end
         SIG_ECDSA:          begin siglen = 65;  ownlen = 65;  end
         SIG_ETH:            begin siglen = 65;  ownlen = 42;  end
         default:            begin siglen = $urandom_range(0, 3); ownlen = 0; end
      endcase
      repeat (siglen + ownlen) win.push_back($urandom_range(0, 255));
      repeat (2) begin
         r = $urandom_range(0, 99);
         if (r < 5) win.push_back($urandom_range(2, 255));
         else if (r < 50) begin
            win.push_back(8'd1);
            repeat (32) win.push_back($urandom_range(0, 255));
         end else win.push_back(8'd0);
      end
      r = $urandom_range(0, 99);
      if (r < 6) begin
         ntags = 0;                        // empty section: ok right after the counts
      end else if (r < 12) begin
         repeat (9) sec.push_back(8'h80);  // overlong varint: fallback
         sec.push_back(8'h01);
         repeat ($urandom_range(0, 3)) sec.push_back($urandom_range(0, 255));
         ntags = 0;
      end else build_section(sec, ntags);
      decl = ntags;
      size = sec.size();
      r = $urandom_range(0, 99);
      if (r < 5) decl = decl + 1;
      else if (r < 10) size = size + $urandom_range(1, 3);
      else if (r < 14 && size > 1) size = size - 1;
      else if (r < 16) decl = {$urandom, $urandom};
      else if (r < 20 && sec.size() > 0)
         sec[$urandom_range(0, sec.size() - 1)] = $urandom_range(0, 255);
      for (int i = 0; i < 8; i++) win.push_back(decl[8*i +: 8]);
      for (int i = 0; i < 8; i++) win.push_back(size[8*i +: 8]);
      foreach (sec[i]) win.push_back(sec[i]);
      repeat ($urandom_range(0, 2)) win.push_back($urandom_range(0, 255));
      // truncate some windows at a random byte, which may cut them off before a verdict
      if ($urandom_range(0, 99) < 12) win = win[0 : $urandom_range(0, win.size() - 1)];
   endtask

   // Compare one response beat with the oldest expectation.
   task automatic check_beat();
      rsp_type e;
      if (due_beats.size() == 0) begin
         $display("%0t: response beat with nothing expected (role %0d)", $time, rsp_byte_role);
         errors++;
         return;
      end
      e = due_beats.pop_front();
      if (rsp_byte_role !== e.byte_role) begin
         $display("%0t: byte_role exp %0d got %0d", $time, e.byte_role, rsp_byte_role);
         errors++;
      end
      if (rsp_tag_index !== e.tag_index) begin
         $display("%0t: tag_index exp %0d got %0d", $time, e.tag_index, rsp_tag_index);
         errors++;
      end
      if (rsp_verdict !== e.verdict) begin
         $display("%0t: verdict exp %0d got %0d", $time, e.verdict, rsp_verdict);
         errors++;
      end
      if (rsp_header_length !== e.header_length) begin
         $display("%0t: header_length exp %0d got %0d", $time, e.header_length,
                  rsp_header_length);
         errors++;
      end
      if (rsp_signature_type !== e.signature_type) begin
         $display("%0t: signature_type exp %0h got %0h", $time, e.signature_type,
                  rsp_signature_type);
         errors++;
      end
      if (rsp_target_present !== e.target_present) begin
         $display("%0t: target_present exp %0d got %0d", $time, e.target_present,
                  rsp_target_present);
         errors++;
      end
      case (e.verdict)
         V_OK:       n_ok++;
         V_FAILED:   n_failed++;
         V_FALLBACK: n_fallback++;
         default:    ;
      endcase
   endtask

   // Long hold-off: count down the stretch in which the receiver takes nothing.
   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      else if (hold_request && !hold_done) begin
         hold_done <= 1;
         hold_left <= LONG_HOLD;
      end
   end

   // Receiver: check each beat, stall at random, and hold off while the stretch runs.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_beat();
      if (reset) rsp_stall <= 1'b0;
      else if (hold_left > 0) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   typedef struct {
      logic [7:0]  b;
      bit          last;
      bit          typed;
      logic [3:0]  role;
      verdict_type v;
   } stim_row_t;

   // Directed rows: bad and truncated signature types, then known types 7, 1, 3 and 4 cut short.
   stim_row_t directed[] = '{
      '{8'h00, 0, 1, ROLE_SIGTYPE, V_PENDING},
      '{8'h05, 0, 1, ROLE_SIGTYPE, V_FAILED},
      '{8'hAB, 1, 1, ROLE_IGNORED, V_FAILED},
      '{8'hFF, 0, 1, ROLE_SIGTYPE, V_PENDING},
      '{8'hFF, 0, 1, ROLE_SIGTYPE, V_FAILED},
      '{8'h00, 1, 1, ROLE_IGNORED, V_FAILED},
      '{8'h02, 1, 1, ROLE_SIGTYPE, V_FAILED},
      '{8'h07, 0, 0, ROLE_SIGTYPE, V_PENDING},
      '{8'h00, 0, 0, ROLE_SIGTYPE, V_PENDING},
      '{8'h55, 1, 1, ROLE_SIG,     V_FAILED},
      '{8'h01, 0, 0, ROLE_SIGTYPE, V_PENDING},
      '{8'h00, 0, 0, ROLE_SIGTYPE, V_PENDING},
      '{8'h80, 0, 0, ROLE_SIG,     V_PENDING},
      '{8'h7F, 1, 1, ROLE_SIG,     V_FAILED},
      '{8'h03, 0, 0, ROLE_SIGTYPE, V_PENDING},
      '{8'h00, 0, 0, ROLE_SIGTYPE, V_PENDING},
      '{8'h00, 1, 1, ROLE_SIG,     V_FAILED},
      '{8'h04, 0, 0, ROLE_SIGTYPE, V_PENDING},
      '{8'h00, 1, 1, ROLE_SIGTYPE, V_FAILED}
   };

   initial begin
      logic [7:0] win[$];
      int         sent;
      clear_parse();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_byte(directed[i].b, directed[i].last, directed[i].typed,
                   directed[i].role, directed[i].v);

      // Random windows; idling and stalling change phase every quarter of the byte budget.
      sent = 0;
      hold_request = 1;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 4) begin idle_pct = 0; stall_pct = 0; end
         else if (sent < RANDOM_ITEMS / 2) begin idle_pct = 73; stall_pct = 0; end
         else if (sent < 3 * RANDOM_ITEMS / 4) begin idle_pct = 0; stall_pct = 73; end
         else begin idle_pct = 10; stall_pct = 10; end
         if ($urandom_range(0, 9) == 0) begin
            // noise: a short run of random bytes closing a window
            repeat ($urandom_range(1, 4)) win.push_back($urandom_range(0, 255));
         end else build_window(win);
         // the byte budget cuts the final window short and closes it there
         foreach (win[i]) begin
            send_byte(win[i], (i == win.size() - 1) || (sent == RANDOM_ITEMS - 1));
            sent++;
            if (sent >= RANDOM_ITEMS) break;
         end
         win.delete();
      end

      req_valid <= 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      while (due_beats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Ran %0d windows: %0d ok, %0d failed and %0d fallback verdicts seen.",
               n_windows, n_ok, n_failed, n_fallback);
      $display("Idling phases and one long response hold-off were exercised.");
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
